[hw/rtl/sql_tokenizer_macros.svh]
// Assertion macros shared by the tokenizer modules.
// Each macro expects clk and rst_n in scope.
`ifndef SQL_TOKENIZER_MACROS_SVH
`define SQL_TOKENIZER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SQLT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sql_tokenizer assertion failed");

// When ante holds, cons must hold at the next clock edge.
`define SQLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sql_tokenizer assertion failed");

`endif

[hw/rtl/sqlt_pkg.sv]
package sqlt_pkg;

  localparam int KW_MAX_LEN = 8;
  localparam int WORD_W = KW_MAX_LEN * 8;
  localparam int WLEN_W = $clog2(KW_MAX_LEN + 2);
  localparam logic [WLEN_W-1:0] WLEN_TOO_LONG = WLEN_W'(KW_MAX_LEN + 1);
  localparam int N_KW = 39;

  localparam logic [5:0] K_EOF   = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd1;
  localparam logic [5:0] K_INT   = 6'd2;
  localparam logic [5:0] K_DEC   = 6'd3;
  localparam logic [5:0] K_STR   = 6'd4;
  localparam logic [5:0] K_LPAR  = 6'd5;
  localparam logic [5:0] K_RPAR  = 6'd6;
  localparam logic [5:0] K_COMMA = 6'd7;
  localparam logic [5:0] K_DOT   = 6'd8;
  localparam logic [5:0] K_SEMI  = 6'd9;
  localparam logic [5:0] K_STAR  = 6'd10;
  localparam logic [5:0] K_PLUS  = 6'd11;
  localparam logic [5:0] K_MINUS = 6'd12;
  localparam logic [5:0] K_SLASH = 6'd13;
  localparam logic [5:0] K_PCT   = 6'd14;
  localparam logic [5:0] K_EQ    = 6'd15;
  localparam logic [5:0] K_NEQ   = 6'd16;
  localparam logic [5:0] K_LT    = 6'd17;
  localparam logic [5:0] K_LE    = 6'd18;
  localparam logic [5:0] K_GT    = 6'd19;
  localparam logic [5:0] K_GE    = 6'd20;
  localparam logic [5:0] K_KW0   = 6'd21;
  localparam logic [5:0] K_ERR   = 6'd60;

  localparam logic [WORD_W-1:0] KW_TEXT [N_KW] = '{
    "SELECT", "FROM", "WHERE", "JOIN", "INNER", "LEFT", "RIGHT", "FULL",
    "OUTER", "ON", "AS", "AND", "OR", "NOT", "BETWEEN", "IN", "IS", "NULL",
    "TRUE", "FALSE", "DISTINCT", "GROUP", "BY", "HAVING", "ORDER", "ASC",
    "DESC", "LIMIT", "OFFSET", "NULLS", "FIRST", "LAST", "DATE", "CAST",
    "COUNT", "SUM", "AVG", "MIN", "MAX"
  };

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_DEC, MODE_STR, MODE_MINUS,
    MODE_COMMENT, MODE_LT, MODE_GT, MODE_BANG, MODE_ERROR
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] text_start;
    logic [31:0] text_end;
    logic [31:0] line_number;
    logic        last_token;
  } out_item_t;

  typedef struct packed {
    out_item_t [2:0] toks;
    logic [1:0]      cnt;
  } bundle_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    sat_inc = (x == '1) ? x : x + 32'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    fold_upper = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
  endfunction

  function automatic logic [5:0] word_kind(input logic [WORD_W-1:0] w,
                                           input logic [WLEN_W-1:0] wl);
    logic [5:0] kind;
    kind = K_IDENT;
    if (wl <= WLEN_W'(KW_MAX_LEN)) begin
      for (int k = 0; k < N_KW; k++) begin
        if (w == KW_TEXT[k]) kind = K_KW0 + 6'(k);
      end
    end
    word_kind = kind;
  endfunction

  function automatic out_item_t mk_tok(input logic [5:0] kind, input logic [31:0] s,
                                       input logic [31:0] e, input logic [31:0] line,
                                       input logic last);
    out_item_t t;
    t.token_kind  = kind;
    t.text_start  = s;
    t.text_end    = e;
    t.line_number = line;
    t.last_token  = last;
    mk_tok = t;
  endfunction

endpackage

[hw/rtl/sql_tokenizer.sv]
// SQL tokenizer. Text enters on the in_ channel one request per byte: data_byte
// with byte_valid set, and end_of_input set on the last request of a text (or
// on a request without a byte). Each token leaves on the out_ channel as one
// request with its kind, text offsets, line and a last_token flag that marks the
// end-of-file or error token. A request can cause zero to three tokens.
// The front lexer takes one input request per cycle and classifies it in that
// cycle; its tokens go as one bundle into a two-entry queue, and the back end
// sends one token per cycle from the queue through an output register.
// The first token passes the queue entry and the output register. The input
// sustains one request per cycle as long as tokens are taken at the rate they
// are made; the output side delivers at most one token per cycle, so requests
// that make several tokens stall the input when the queue fills.
// When out_ready is low the output register holds, the queue fills and in_ready
// drops; no token is lost. The cfg_ channel writes the first line number and is
// always ready; in_ready is held low in a cycle that offers a cfg_ write.
// Synchronous reset clears the lexer state, empties the queue and sets the
// first line number to one.
module sql_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sqlt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sqlt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic              push_valid, push_ready, head_valid, pop;
  sqlt_pkg::bundle_t push_data, head_data;

  sqlt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  sqlt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  sqlt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[hw/rtl/sqlt_front.sv]
module sqlt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sqlt_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output logic                push_valid,
  output sqlt_pkg::bundle_t   push_data,
  input  logic                push_ready
);

  sqlt_pkg::mode_t mode_r, mode_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] start_r, start_nxt;
  logic [sqlt_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [sqlt_pkg::WLEN_W-1:0] wlen_r, wlen_nxt;
  logic [15:0] first_r, first_nxt;
  logic accept;

  assign in_ready  = push_ready && !cfg_valid;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    sqlt_pkg::mode_t m;
    logic [31:0] p, e, op_end, pos_v, lc, ts;
    logic [sqlt_pkg::WORD_W-1:0] w;
    logic [sqlt_pkg::WLEN_W-1:0] wl;
    logic consumed;
    logic [7:0] c;
    sqlt_pkg::out_item_t t [3];
    logic [1:0] n;

    m = mode_r; pos_v = pos_r; lc = line_r; ts = start_r; w = word_r; wl = wlen_r;
    c = in_data.data_byte;
    consumed = 1'b0;
    n = 2'd0;
    for (int i = 0; i < 3; i++) t[i] = '0;
    p = pos_r;
    e = sqlt_pkg::sat_inc(pos_r);
    op_end = sqlt_pkg::sat_inc(start_r);
    first_nxt = first_r;

    if (accept && in_data.byte_valid) begin
      case (m)
        sqlt_pkg::MODE_IDLE: consumed = 1'b0;
        sqlt_pkg::MODE_IDENT: begin
          if (sqlt_pkg::is_alpha(c) || sqlt_pkg::is_digit(c) || c == "_") begin
            if (wl < sqlt_pkg::WLEN_W'(sqlt_pkg::KW_MAX_LEN)) begin
              w = {w[sqlt_pkg::WORD_W-9:0], sqlt_pkg::fold_upper(c)};
              wl = wl + sqlt_pkg::WLEN_W'(1);
            end else begin
              wl = sqlt_pkg::WLEN_TOO_LONG;
            end
            consumed = 1'b1;
          end else begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::word_kind(w, wl), ts, p, lc, 1'b0);
            n = n + 2'd1;
          end
        end
        sqlt_pkg::MODE_INT: begin
          if (sqlt_pkg::is_digit(c)) begin
            consumed = 1'b1;
          end else if (c == ".") begin
            m = sqlt_pkg::MODE_DEC;
            consumed = 1'b1;
          end else begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_INT, ts, p, lc, 1'b0);
            n = n + 2'd1;
          end
        end
        sqlt_pkg::MODE_DEC: begin
          if (sqlt_pkg::is_digit(c)) begin
            consumed = 1'b1;
          end else begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_DEC, ts, p, lc, 1'b0);
            n = n + 2'd1;
          end
        end
        sqlt_pkg::MODE_STR: begin
          if (c == "'") begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_STR, ts, p, lc, 1'b0);
            n = n + 2'd1;
            m = sqlt_pkg::MODE_IDLE;
          end else if (c == 8'd10) begin
            lc = sqlt_pkg::sat_inc(lc);
          end
          consumed = 1'b1;
        end
        sqlt_pkg::MODE_MINUS: begin
          if (c == "-") begin
            m = sqlt_pkg::MODE_COMMENT;
            consumed = 1'b1;
          end else begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_MINUS, ts, op_end, lc, 1'b0);
            n = n + 2'd1;
          end
        end
        sqlt_pkg::MODE_COMMENT: consumed = (c != 8'd10);
        sqlt_pkg::MODE_LT: begin
          if (c == "=" || c == ">") begin
            t[n] = sqlt_pkg::mk_tok((c == "=") ? sqlt_pkg::K_LE : sqlt_pkg::K_NEQ,
                                    ts, e, lc, 1'b0);
            n = n + 2'd1;
            m = sqlt_pkg::MODE_IDLE;
            consumed = 1'b1;
          end else begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_LT, ts, op_end, lc, 1'b0);
            n = n + 2'd1;
          end
        end
        sqlt_pkg::MODE_GT: begin
          if (c == "=") begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_GE, ts, e, lc, 1'b0);
            n = n + 2'd1;
            m = sqlt_pkg::MODE_IDLE;
            consumed = 1'b1;
          end else begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_GT, ts, op_end, lc, 1'b0);
            n = n + 2'd1;
          end
        end
        sqlt_pkg::MODE_BANG: begin
          if (c == "=") begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_NEQ, ts, e, lc, 1'b0);
            m = sqlt_pkg::MODE_IDLE;
          end else begin
            t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_ERR, ts, op_end, lc, 1'b1);
            m = sqlt_pkg::MODE_ERROR;
          end
          n = n + 2'd1;
          consumed = 1'b1;
        end
        sqlt_pkg::MODE_ERROR: consumed = 1'b1;
        default: consumed = 1'b0;
      endcase

      if (!consumed) begin
        m = sqlt_pkg::MODE_IDLE;
        ts = p;
        if (c == 8'd10) begin
          lc = sqlt_pkg::sat_inc(lc);
        end else if (sqlt_pkg::is_space(c)) begin
          m = sqlt_pkg::MODE_IDLE;
        end else if (sqlt_pkg::is_digit(c)) begin
          m = sqlt_pkg::MODE_INT;
        end else if (c == "'") begin
          ts = e;
          m = sqlt_pkg::MODE_STR;
        end else if (sqlt_pkg::is_alpha(c) || c == "_") begin
          w = {{(sqlt_pkg::WORD_W-8){1'b0}}, sqlt_pkg::fold_upper(c)};
          wl = sqlt_pkg::WLEN_W'(1);
          m = sqlt_pkg::MODE_IDENT;
        end else begin
          case (c)
            "(": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_LPAR, p, e, lc, 1'b0);
              n = n + 2'd1; end
            ")": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_RPAR, p, e, lc, 1'b0);
              n = n + 2'd1; end
            ",": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_COMMA, p, e, lc, 1'b0);
              n = n + 2'd1; end
            ".": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_DOT, p, e, lc, 1'b0);
              n = n + 2'd1; end
            ";": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_SEMI, p, e, lc, 1'b0);
              n = n + 2'd1; end
            "*": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_STAR, p, e, lc, 1'b0);
              n = n + 2'd1; end
            "+": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_PLUS, p, e, lc, 1'b0);
              n = n + 2'd1; end
            "/": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_SLASH, p, e, lc, 1'b0);
              n = n + 2'd1; end
            "%": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_PCT, p, e, lc, 1'b0);
              n = n + 2'd1; end
            "=": begin t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_EQ, p, e, lc, 1'b0);
              n = n + 2'd1; end
            "-": m = sqlt_pkg::MODE_MINUS;
            "<": m = sqlt_pkg::MODE_LT;
            ">": m = sqlt_pkg::MODE_GT;
            "!": m = sqlt_pkg::MODE_BANG;
            default: begin
              t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_ERR, p, e, lc, 1'b1);
              n = n + 2'd1;
              m = sqlt_pkg::MODE_ERROR;
            end
          endcase
        end
      end
      pos_v = sqlt_pkg::sat_inc(pos_r);
    end

    if (accept && in_data.end_of_input) begin
      op_end = sqlt_pkg::sat_inc(ts);
      case (m)
        sqlt_pkg::MODE_IDENT: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::word_kind(w, wl), ts, pos_v, lc, 1'b0);
          n = n + 2'd1;
        end
        sqlt_pkg::MODE_INT: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_INT, ts, pos_v, lc, 1'b0);
          n = n + 2'd1;
        end
        sqlt_pkg::MODE_DEC: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_DEC, ts, pos_v, lc, 1'b0);
          n = n + 2'd1;
        end
        sqlt_pkg::MODE_STR: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_STR, ts, pos_v, lc, 1'b0);
          n = n + 2'd1;
        end
        sqlt_pkg::MODE_MINUS: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_MINUS, ts, op_end, lc, 1'b0);
          n = n + 2'd1;
        end
        sqlt_pkg::MODE_LT: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_LT, ts, op_end, lc, 1'b0);
          n = n + 2'd1;
        end
        sqlt_pkg::MODE_GT: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_GT, ts, op_end, lc, 1'b0);
          n = n + 2'd1;
        end
        sqlt_pkg::MODE_BANG: begin
          t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_ERR, ts, op_end, lc, 1'b1);
          n = n + 2'd1;
          m = sqlt_pkg::MODE_ERROR;
        end
        default: ;
      endcase
      if (m != sqlt_pkg::MODE_ERROR) begin
        t[n] = sqlt_pkg::mk_tok(sqlt_pkg::K_EOF, pos_v, pos_v, lc, 1'b1);
        n = n + 2'd1;
      end
      m = sqlt_pkg::MODE_IDLE;
      pos_v = '0;
      lc = {16'd0, first_r};
      ts = '0;
      wl = '0;
      w = '0;
    end

    if (cfg_valid && !accept) begin
      first_nxt = cfg_data;
      if (pos_r == '0 && mode_r == sqlt_pkg::MODE_IDLE) lc = {16'd0, cfg_data};
    end

    mode_nxt = m;
    pos_nxt = pos_v;
    line_nxt = lc;
    start_nxt = ts;
    word_nxt = w;
    wlen_nxt = wl;
    push_valid = accept && (n != 2'd0);
    push_data.toks[0] = t[0];
    push_data.toks[1] = t[1];
    push_data.toks[2] = t[2];
    push_data.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sqlt_pkg::MODE_IDLE;
      pos_r   <= '0;
      line_r  <= 32'd1;
      start_r <= '0;
      wlen_r  <= '0;
      first_r <= 16'd1;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
      wlen_r  <= wlen_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

`include "sql_tokenizer_macros.svh"
  `SQLT_ASSERT_ALWAYS(a_front_ident_len, mode_r != sqlt_pkg::MODE_IDENT || wlen_r != '0)
  `SQLT_ASSERT_NEXT(a_front_eof_resets, accept && in_data.end_of_input,
                    pos_r == '0 && mode_r == sqlt_pkg::MODE_IDLE)
  `SQLT_ASSERT_ALWAYS(a_front_err_quiet, !(push_valid && mode_r == sqlt_pkg::MODE_ERROR
                      && !in_data.end_of_input))

endmodule

[hw/rtl/sqlt_queue.sv]
module sqlt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  sqlt_pkg::bundle_t push_data,
  output logic              push_ready,
  output logic              head_valid,
  output sqlt_pkg::bundle_t head_data,
  input  logic              pop
);

  sqlt_pkg::bundle_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_data;
  end

`include "sql_tokenizer_macros.svh"
  `SQLT_ASSERT_ALWAYS(a_queue_count, cnt_r != 2'd3)
  `SQLT_ASSERT_ALWAYS(a_queue_nonempty_bundle, !do_push || push_data.cnt != 2'd0)
  `SQLT_ASSERT_ALWAYS(a_queue_ptrs, (cnt_r == 2'd1) == (wr_ptr_r != rd_ptr_r))

endmodule

[hw/rtl/sqlt_back.sv]
module sqlt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  sqlt_pkg::bundle_t   head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sqlt_pkg::out_item_t out_data
);

  logic                out_valid_r, out_valid_nxt;
  sqlt_pkg::out_item_t out_data_r, out_data_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                load;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (idx_r == head_data.cnt - 2'd1);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      case (idx_r)
        2'd0: out_data_nxt = head_data.toks[0];
        2'd1: out_data_nxt = head_data.toks[1];
        default: out_data_nxt = head_data.toks[2];
      endcase
      idx_nxt = pop ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "sql_tokenizer_macros.svh"
  `SQLT_ASSERT_ALWAYS(a_back_idx, !head_valid || idx_r < head_data.cnt)
  `SQLT_ASSERT_ALWAYS(a_back_idx_zero, head_valid || idx_r == 2'd0)

endmodule

[tb/tb_sql_tokenizer.sv]
`timescale 1ns / 1ps

module tb_sql_tokenizer;
  import sqlt_pkg::*;

  localparam int NUM_KEYWORDS = 39;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    SC_IDLE, SC_IDENT, SC_INT, SC_DEC, SC_STR, SC_MINUS, SC_COMMENT,
    SC_LT, SC_GT, SC_BANG, SC_ERROR
  } scan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  sql_tokenizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  string keywords [NUM_KEYWORDS] = '{
    "SELECT", "FROM", "WHERE", "JOIN", "INNER", "LEFT", "RIGHT", "FULL",
    "OUTER", "ON", "AS", "AND", "OR", "NOT", "BETWEEN", "IN", "IS", "NULL",
    "TRUE", "FALSE", "DISTINCT", "GROUP", "BY", "HAVING", "ORDER", "ASC",
    "DESC", "LIMIT", "OFFSET", "NULLS", "FIRST", "LAST", "DATE", "CAST",
    "COUNT", "SUM", "AVG", "MIN", "MAX"
  };

  // Lexer state mirrored by the token predictor.
  logic [15:0] first_line;
  scan_t       scan;
  logic [31:0] pos;
  logic [31:0] line_cnt;
  logic [31:0] tok_start;
  string       word;
  int          word_len;

  in_item_t  pending_requests [$];
  out_item_t expected_tokens [$];
  int        mismatches = 0;
  longint    cycles = 0;
  bit        hold_input = 1'b0;
  bit        cfg_pending = 1'b0;
  logic [15:0] cfg_value;

  function automatic logic [31:0] inc32(logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void add_token(logic [5:0] k, logic [31:0] s, logic [31:0] e,
                                    logic last);
    out_item_t t;
    t.token_kind = k;
    t.text_start = s;
    t.text_end = e;
    t.line_number = line_cnt;
    t.last_token = last;
    expected_tokens.push_back(t);
  endfunction

  function automatic void add_letter(logic [7:0] c);
    if (word_len < KW_MAX_LEN) begin
      word = {word, string'((c >= "a" && c <= "z") ? c - 8'd32 : c)};
      word_len++;
    end else begin
      word_len = KW_MAX_LEN + 1;
    end
  endfunction

  function automatic logic [5:0] classify_word();
    if (word_len <= KW_MAX_LEN)
      for (int k = 0; k < NUM_KEYWORDS; k++)
        if (keywords[k] == word) return K_KW0 + 6'(k);
    return K_IDENT;
  endfunction

  function automatic void flag_error(logic [31:0] p);
    add_token(K_ERR, p, inc32(p), 1'b1);
    scan = SC_ERROR;
  endfunction

  function automatic void restart_text();
    scan = SC_IDLE;
    pos = '0;
    line_cnt = {16'd0, first_line};
    tok_start = '0;
    word = "";
    word_len = 0;
  endfunction

  function automatic void start_token(logic [7:0] c, logic [31:0] p);
    logic [31:0] e;
    e = inc32(p);
    tok_start = p;
    if (c == 8'd10) line_cnt = inc32(line_cnt);
    else if (c == " " || (c >= 8'd9 && c <= 8'd13)) ;
    else if (digit_c(c)) scan = SC_INT;
    else if (c == "'") begin
      tok_start = e;
      scan = SC_STR;
    end else if (alpha_c(c) || c == "_") begin
      word = "";
      word_len = 0;
      add_letter(c);
      scan = SC_IDENT;
    end else begin
      case (c)
        "(": add_token(K_LPAR, p, e, 1'b0);
        ")": add_token(K_RPAR, p, e, 1'b0);
        ",": add_token(K_COMMA, p, e, 1'b0);
        ".": add_token(K_DOT, p, e, 1'b0);
        ";": add_token(K_SEMI, p, e, 1'b0);
        "*": add_token(K_STAR, p, e, 1'b0);
        "+": add_token(K_PLUS, p, e, 1'b0);
        "/": add_token(K_SLASH, p, e, 1'b0);
        "%": add_token(K_PCT, p, e, 1'b0);
        "=": add_token(K_EQ, p, e, 1'b0);
        "-": scan = SC_MINUS;
        "<": scan = SC_LT;
        ">": scan = SC_GT;
        "!": scan = SC_BANG;
        default: flag_error(p);
      endcase
    end
  endfunction

  // Returns 1 when the pending token absorbs the byte.
  function automatic bit continue_token(logic [7:0] c, logic [31:0] p);
    logic [31:0] op_end;
    logic [31:0] e;
    op_end = inc32(tok_start);
    e = inc32(p);
    case (scan)
      SC_IDENT: begin
        if (alpha_c(c) || digit_c(c) || c == "_") begin
          add_letter(c);
          return 1;
        end
        add_token(classify_word(), tok_start, p, 1'b0);
      end
      SC_INT: begin
        if (digit_c(c)) return 1;
        if (c == ".") begin
          scan = SC_DEC;
          return 1;
        end
        add_token(K_INT, tok_start, p, 1'b0);
      end
      SC_DEC: begin
        if (digit_c(c)) return 1;
        add_token(K_DEC, tok_start, p, 1'b0);
      end
      SC_STR: begin
        if (c == "'") begin
          add_token(K_STR, tok_start, p, 1'b0);
          scan = SC_IDLE;
        end else if (c == 8'd10) begin
          line_cnt = inc32(line_cnt);
        end
        return 1;
      end
      SC_MINUS: begin
        if (c == "-") begin
          scan = SC_COMMENT;
          return 1;
        end
        add_token(K_MINUS, tok_start, op_end, 1'b0);
      end
      SC_COMMENT: if (c != 8'd10) return 1;
      SC_LT: begin
        if (c == "=" || c == ">") begin
          add_token(c == "=" ? K_LE : K_NEQ, tok_start, e, 1'b0);
          scan = SC_IDLE;
          return 1;
        end
        add_token(K_LT, tok_start, op_end, 1'b0);
      end
      SC_GT: begin
        if (c == "=") begin
          add_token(K_GE, tok_start, e, 1'b0);
          scan = SC_IDLE;
          return 1;
        end
        add_token(K_GT, tok_start, op_end, 1'b0);
      end
      SC_BANG: begin
        if (c == "=") begin
          add_token(K_NEQ, tok_start, e, 1'b0);
          scan = SC_IDLE;
        end else begin
          flag_error(tok_start);
        end
        return 1;
      end
      SC_ERROR: return 1;
      default: ;
    endcase
    scan = SC_IDLE;
    return 0;
  endfunction

  function automatic void predict_tokens(in_item_t r);
    logic [31:0] op_end;
    if (r.byte_valid) begin
      if (scan == SC_IDLE || !continue_token(r.data_byte, pos))
        start_token(r.data_byte, pos);
      pos = inc32(pos);
    end
    if (r.end_of_input) begin
      op_end = inc32(tok_start);
      case (scan)
        SC_IDENT: add_token(classify_word(), tok_start, pos, 1'b0);
        SC_INT: add_token(K_INT, tok_start, pos, 1'b0);
        SC_DEC: add_token(K_DEC, tok_start, pos, 1'b0);
        SC_STR: add_token(K_STR, tok_start, pos, 1'b0);
        SC_MINUS: add_token(K_MINUS, tok_start, op_end, 1'b0);
        SC_LT: add_token(K_LT, tok_start, op_end, 1'b0);
        SC_GT: add_token(K_GT, tok_start, op_end, 1'b0);
        SC_BANG: flag_error(tok_start);
        default: ;
      endcase
      if (scan != SC_ERROR) add_token(K_EOF, pos, pos, 1'b1);
      restart_text();
    end
  endfunction

  function automatic void push_byte(logic [7:0] c, bit last);
    in_item_t r;
    r.data_byte = c;
    r.byte_valid = 1'b1;
    r.end_of_input = last;
    pending_requests.push_back(r);
  endfunction

  function automatic void push_text(string s, bit terminate);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], terminate && i == s.len() - 1);
  endfunction

  function automatic void push_marker(bit last, logic [7:0] junk);
    in_item_t r;
    r.data_byte = junk;
    r.byte_valid = 1'b0;
    r.end_of_input = last;
    pending_requests.push_back(r);
  endfunction

  function automatic string random_lexeme();
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 13))
      0, 1: s = keywords[$urandom_range(0, NUM_KEYWORDS - 1)];
      2: begin
        n = $urandom_range(1, 11);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: s = {s, string'(8'($urandom_range("a", "z")))};
            1: s = {s, string'(8'($urandom_range("A", "Z")))};
            2: s = {s, "_"};
            default: s = {s, string'(8'($urandom_range("0", "9")))};
          endcase
        end
        if (digit_c(s[0])) s = {"x", s};
      end
      3: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
        if ($urandom_range(0, 1)) s = {s, ".", $sformatf("%0d", $urandom_range(0, 99))};
      end
      4: s = $urandom_range(0, 3) == 0 ? "'a\nb'" : "'it is'";
      5: begin
        string ops [14] = '{"(", ")", ",", ".", ";", "*", "+", "-", "/", "%", "=",
                           "<", ">", "!="};
        s = ops[$urandom_range(0, 13)];
      end
      6: begin
        string ops2 [4] = '{"<=", ">=", "<>", "--c x\n"};
        s = ops2[$urandom_range(0, 3)];
      end
      7: s = $urandom_range(0, 1) ? "\n" : "\t";
      8: s = {"", string'(8'($urandom_range(0, 255)))};
      default: s = " ";
    endcase
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_tokens.size() != 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_first_line(logic [15:0] v);
    wait_drained();
    cfg_value = v;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        first_line = cfg_data;
        if (pos == 0 && scan == SC_IDLE) line_cnt = {16'd0, cfg_data};
        cfg_valid <= 1'b0;
        cfg_pending = 1'b0;
      end else if (cfg_pending && !cfg_valid) begin
        cfg_valid <= 1'b1;
        cfg_data <= cfg_value;
      end
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      logic take_next;
      take_next = 1'b0;
      if (in_valid && in_ready) predict_tokens(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!hold_input && pending_requests.size() != 0) begin
          take_next = 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
          end
        end
        if (take_next) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected token: %p", out_data);
        end else begin
          out_item_t x;
          x = expected_tokens.pop_front();
          if (x !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("Token mismatch: expected %p, got %p", x, out_data);
          end
        end
      end
      out_ready <= ((cycles / 64) % 4 == 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    string s;
    first_line = 16'd1;
    restart_text();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_text("SELECT DISTINCT a_1,b FROM t WHERE x<=3.5 AND y<>'s'", 1);
    push_text("select count(*) from abcdefghi; x>=1 -- note\n z!=2 % 4 / 5 + 6.", 1);
    push_text("a<b>c-d 12 'open", 1);
    push_marker(1, 8'hFF);
    push_marker(0, 8'hAA);
    push_text("x ! y", 1);
    push_text("p @ q ? r", 1);
    push_byte(8'h80, 0);
    push_byte(8'hFF, 1);
    push_text("nulls first\nlast", 0);
    push_text("<", 1);
    push_text("!", 1);
    write_first_line(16'd0);
    push_text("a\n-\n>", 1);
    write_first_line(16'hFFFF);
    push_text("order by 9\n", 1);

    for (int phase = 0; phase < 6; phase++) begin
      int count;
      case (phase)
        1: write_first_line(16'($urandom_range(0, 65535)));
        3: write_first_line(16'd1);
        5: write_first_line(16'd7);
        default: ;
      endcase
      count = 0;
      while (count < 45) begin
        s = random_lexeme();
        if ($urandom_range(0, 4) != 0 && s != " " && s != "\n") s = {s, " "};
        push_text(s, 0);
        count += s.len();
        if ($urandom_range(0, 19) == 0) push_marker(0, 8'($urandom));
        if ($urandom_range(0, 24) == 0) begin
          push_marker(1, 8'($urandom));
          count++;
        end
      end
      push_byte(8'($urandom_range(0, 255)), 1);
      if (phase == 2) begin
        wait_drained();
        hold_input = 1'b1;
        repeat (20) @(posedge clk);
        hold_input = 1'b0;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
